/* rtl/ipv4hc_pkg.sv */
// Shared types, constants and a function for the IPv4 receive header check.
package ipv4hc_pkg;

    localparam int HDR_BYTES = 20;
    localparam int CNT_W     = 5;

    // Byte positions inside the fixed IPv4 header.
    localparam logic [CNT_W-1:0] POS_VERSION  = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_TLEN_HI  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_TLEN_LO  = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_PROTOCOL = CNT_W'(9);
    localparam logic [CNT_W-1:0] POS_CSUM_HI  = CNT_W'(10);
    localparam logic [CNT_W-1:0] POS_CSUM_LO  = CNT_W'(11);
    localparam logic [CNT_W-1:0] POS_SRC_FIRST = CNT_W'(12);
    localparam logic [CNT_W-1:0] POS_DST_FIRST = CNT_W'(16);
    localparam logic [CNT_W-1:0] POS_LAST     = CNT_W'(HDR_BYTES - 1);

    localparam logic [3:0] VERSION_IPV4  = 4'd4;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_UDP     = 8'd17;

    typedef enum logic [2:0] {
        VERDICT_DELIVER     = 3'd0,
        VERDICT_TOO_SHORT   = 3'd1,
        VERDICT_BAD_VERSION = 3'd2,
        VERDICT_BAD_CSUM    = 3'd3,
        VERDICT_NOT_FOR_US  = 3'd4,
        VERDICT_PROTO_UNRCH = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_end;
        logic [15:0] received_len;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [15:0] padding_len;
    } t_out_item;

    // Ones-complement addition of two 16-bit words with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

/* rtl/ipv4_rx_header_check_top.sv */
// IPv4 receive header check: byte-wide header parser with one verdict per packet.
//
// Packet bytes enter on the input channel (i_in_valid / o_in_ready), header
// first, each with the received buffer length and an end-of-packet flag. The
// local host address is loaded through i_cfg_we / i_cfg_wdata; the user must
// do so only while idle, as the block does not enforce it. Verdicts leave on
// the output channel (o_out_valid / i_out_ready): one per packet, at the last
// header byte, or at an end flag that arrives earlier. Bytes after the header
// produce nothing, and all packet state clears at each end flag.
// A byte is held in an input register, then parsed and checked combinationally
// into the output register, from which its verdict leaves. One byte is taken
// per cycle, sustained, as long as no verdict waits on a stalled receiver.
// When the receiver stalls, the held verdict stays in the output register;
// bytes that produce no verdict keep flowing, and a byte that would produce
// one waits in the input register until the output register drains.
// A synchronous active-low reset empties both registers, clears the packet
// state and sets the local address to zero.
module ipv4_rx_header_check_top
    import ipv4hc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0]      r_local_ip;
    logic             r_s1_valid;
    t_in_item         r_s1_data;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_word_sum, n_word_sum;
    logic [7:0]       r_high_byte, n_high_byte;
    logic [3:0]       r_version, n_version;
    logic [15:0]      r_total_len, n_total_len;
    logic [7:0]       r_protocol, n_protocol;
    logic [15:0]      r_stored_csum, n_stored_csum;
    logic [31:0]      r_source_addr, n_source_addr;
    logic [31:0]      r_dest_addr, n_dest_addr;
    logic             r_verdict_given, n_verdict_given;

    logic             take;
    logic             hdr_done;
    logic             early_end;
    logic             has_result;
    logic             out_free;
    logic             s1_adv;
    logic             short_pkt;
    logic [31:0]      last_dst;
    logic [15:0]      last_sum;
    t_verdict         verdict;
    t_out_item        result;

    assign take       = r_s1_valid && !r_verdict_given;
    assign hdr_done   = take && (r_byte_count == POS_LAST);
    assign early_end  = take && !hdr_done && r_s1_data.packet_end;
    assign has_result = hdr_done || early_end;
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (out_free || !has_result);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // The last header byte completes the destination address and the final checksum word.
    assign last_dst = {r_dest_addr[23:0], r_s1_data.data_byte};
    assign last_sum = ones_add(r_word_sum, {r_high_byte, r_s1_data.data_byte});

    // Field capture and checksum accumulation for the byte in the input register.
    always_comb begin
        n_byte_count    = r_byte_count;
        n_word_sum      = r_word_sum;
        n_high_byte     = r_high_byte;
        n_version       = r_version;
        n_total_len     = r_total_len;
        n_protocol      = r_protocol;
        n_stored_csum   = r_stored_csum;
        n_source_addr   = r_source_addr;
        n_dest_addr     = r_dest_addr;
        n_verdict_given = r_verdict_given;

        if (take) begin
            priority if (r_byte_count == POS_VERSION) begin
                n_version = r_s1_data.data_byte[7:4];
            end else if (r_byte_count == POS_TLEN_HI) begin
                n_total_len = {r_s1_data.data_byte, 8'd0};
            end else if (r_byte_count == POS_TLEN_LO) begin
                n_total_len = {r_total_len[15:8], r_s1_data.data_byte};
            end else if (r_byte_count == POS_PROTOCOL) begin
                n_protocol = r_s1_data.data_byte;
            end else if (r_byte_count == POS_CSUM_HI) begin
                n_stored_csum = {r_s1_data.data_byte, 8'd0};
            end else if (r_byte_count == POS_CSUM_LO) begin
                n_stored_csum = {r_stored_csum[15:8], r_s1_data.data_byte};
            end else if (r_byte_count >= POS_SRC_FIRST && r_byte_count < POS_DST_FIRST) begin
                n_source_addr = {r_source_addr[23:0], r_s1_data.data_byte};
            end else if (r_byte_count >= POS_DST_FIRST) begin
                n_dest_addr = {r_dest_addr[23:0], r_s1_data.data_byte};
            end else begin
                n_version = r_version;
            end

            // Odd positions close a big-endian word; the checksum word is skipped.
            if (r_byte_count[0]) begin
                if (r_byte_count != POS_CSUM_LO) begin
                    n_word_sum = ones_add(r_word_sum, {r_high_byte, r_s1_data.data_byte});
                end
            end else begin
                n_high_byte = r_s1_data.data_byte;
            end

            n_byte_count = r_byte_count + CNT_W'(1);
            if (hdr_done) begin
                n_verdict_given = 1'b1;
            end
        end

        if (r_s1_valid && r_s1_data.packet_end) begin
            n_byte_count    = '0;
            n_word_sum      = '0;
            n_high_byte     = '0;
            n_version       = '0;
            n_total_len     = '0;
            n_protocol      = '0;
            n_stored_csum   = '0;
            n_source_addr   = '0;
            n_dest_addr     = '0;
            n_verdict_given = 1'b0;
        end
    end

    // Verdict, checked in priority order on the header fields as they stand after the
    // last header byte, before any end-of-packet clear.
    always_comb begin
        short_pkt = r_s1_data.received_len < 16'(HDR_BYTES);
        priority if (early_end || short_pkt) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (r_version != VERSION_IPV4) begin
            verdict = VERDICT_BAD_VERSION;
        end else if (~last_sum != r_stored_csum) begin
            verdict = VERDICT_BAD_CSUM;
        end else if (last_dst != r_local_ip) begin
            verdict = VERDICT_NOT_FOR_US;
        end else if (r_protocol != PROTO_ICMP && r_protocol != PROTO_UDP) begin
            verdict = VERDICT_PROTO_UNRCH;
        end else begin
            verdict = VERDICT_DELIVER;
        end

        result.verdict = verdict;
        if (verdict == VERDICT_TOO_SHORT) begin
            result.protocol    = '0;
            result.source_ip   = '0;
            result.padding_len = '0;
        end else begin
            result.protocol  = r_protocol;
            result.source_ip = r_source_addr;
            if (r_total_len < r_s1_data.received_len) begin
                result.padding_len = r_s1_data.received_len - r_total_len;
            end else begin
                result.padding_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_we) begin
            r_local_ip <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_word_sum      <= '0;
            r_high_byte     <= '0;
            r_version       <= '0;
            r_total_len     <= '0;
            r_protocol      <= '0;
            r_stored_csum   <= '0;
            r_source_addr   <= '0;
            r_dest_addr     <= '0;
            r_verdict_given <= 1'b0;
        end else if (s1_adv) begin
            r_byte_count    <= n_byte_count;
            r_word_sum      <= n_word_sum;
            r_high_byte     <= n_high_byte;
            r_version       <= n_version;
            r_total_len     <= n_total_len;
            r_protocol      <= n_protocol;
            r_stored_csum   <= n_stored_csum;
            r_source_addr   <= n_source_addr;
            r_dest_addr     <= n_dest_addr;
            r_verdict_given <= n_verdict_given;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && has_result) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The counter parks at the header length exactly while a verdict is out.
    a_count_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict_given |-> (r_byte_count == CNT_W'(HDR_BYTES)))
        else $error("byte count not parked after verdict");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_verdict_given |-> (r_byte_count < CNT_W'(HDR_BYTES)))
        else $error("byte count ran past header without verdict");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.verdict == VERDICT_TOO_SHORT) |->
        (o_out_data.protocol == 8'd0 && o_out_data.source_ip == 32'd0
         && o_out_data.padding_len == 16'd0))
        else $error("too-short verdict carries nonzero fields");

    // A new verdict is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(s1_adv && has_result))
        else $error("pending verdict overwritten");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !o_out_valid))
        else $error("pipeline not empty after reset");

endmodule
